>>> src/clle_pkg.sv
package clle_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int ID_W       = 10;
   localparam int FUNC_W     = 3;
   localparam int REQ_BITS   = FUNC_W + 2 * ID_W;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W      = ((ID_W + 7) / 8) * 8;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [ID_W-1:0]   id_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam func_type FUNC_LOAD = 3'd0;
   localparam func_type BN        = 3'd1;
   localparam func_type BP        = 3'd2;
   localparam func_type CN        = 3'd3;
   localparam func_type CP        = 3'd4;

   function automatic addr_type slot(input id_type id);
      logic [31:0] wide;
      begin
         wide = 32'(id) % NODE_COUNT;
         return wide[ADDR_W-1:0];
      end
   endfunction

endpackage

>>> src/circular_linked_list_engine.sv
// Circular doubly linked list of node ids, held in a next table and a prev table,
// each a synchronous memory with one write port and one read port. Load transactions
// append ids and keep the ring closed; the load with tlast set ends the load run.
// Insert-after, insert-before, delete-next and delete-prev each return one transaction
// holding the anchor's former neighbour. One transaction is worked on at a time: a load
// writes both memories in S_LOAD and S_LOAD2; an insert reads the anchor's neighbour and
// writes each memory in S_READ and S_WR2; a delete reads the neighbour and its neighbour
// and writes each memory in S_READ2. A result waits in an output register, and the next
// request may be accepted while it waits; an insert or a delete that finishes while an
// earlier result is still waiting holds the input until that result is taken.
module circular_linked_list_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [clle_pkg::REQ_W-1:0]  req_tdata,  // func, anchor_id, new_id
   input  logic                        req_tlast,  // load_last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [clle_pkg::RSP_W-1:0]  rsp_tdata   // neighbour_id
);
   import clle_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_LOAD2, S_READ, S_READ2, S_WR2, S_DONE
   } state_type;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   id_type    anchor_ff, anchor_in;
   id_type    new_ff, new_in;
   id_type    n_ff, n_in;
   id_type    first_ff, first_in;
   id_type    recent_ff, recent_in;
   id_type    rsp_data_ff, rsp_data_in;
   logic      last_ff, last_in;
   logic      open_ff, open_in;
   logic      rsp_valid_ff, rsp_valid_in;

   id_type    next_mem [NODE_COUNT];
   id_type    prev_mem [NODE_COUNT];
   id_type    next_rd_ff, prev_rd_ff;
   addr_type  rd_addr;
   logic      next_we, prev_we;
   id_type    next_wid, next_wdata, prev_wid, prev_wdata;

   func_type  req_func;
   id_type    req_anchor, req_new;
   id_type    nb_sel, rec_eff, first_eff;

   assign req_func   = req_tdata[FUNC_W-1:0];
   assign req_anchor = req_tdata[FUNC_W +: ID_W];
   assign req_new    = req_tdata[FUNC_W + ID_W +: ID_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - ID_W){1'b0}}, rsp_data_ff};

   assign nb_sel    = (func_ff == BN || func_ff == CN) ? next_rd_ff : prev_rd_ff;
   assign rec_eff   = open_ff ? recent_ff : new_ff;
   assign first_eff = open_ff ? first_ff : new_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      anchor_in    = anchor_ff;
      new_in       = new_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      recent_in    = recent_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = slot(req_anchor);
      next_we      = 1'b0;
      prev_we      = 1'b0;
      next_wid     = new_ff;
      next_wdata   = anchor_ff;
      prev_wid     = new_ff;
      prev_wdata   = anchor_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_func;
               anchor_in = req_anchor;
               new_in    = req_new;
               last_in   = req_tlast;
               case (req_func)
                  FUNC_LOAD:      state_in = S_LOAD;
                  BN, BP, CN, CP: state_in = S_READ;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            prev_we    = 1'b1;
            prev_wid   = new_ff;
            prev_wdata = rec_eff;
            next_we    = 1'b1;
            next_wid   = rec_eff;
            next_wdata = new_ff;
            first_in   = first_eff;
            open_in    = 1'b1;
            state_in   = S_LOAD2;
         end
         S_LOAD2: begin
            next_we    = 1'b1;
            next_wid   = new_ff;
            next_wdata = first_ff;
            prev_we    = 1'b1;
            prev_wid   = first_ff;
            prev_wdata = new_ff;
            recent_in  = new_ff;
            open_in    = !last_ff;
            state_in   = S_IDLE;
         end
         S_READ: begin
            n_in    = nb_sel;
            rd_addr = slot(nb_sel);
            case (func_ff)
               BN: begin
                  next_we    = 1'b1;
                  next_wid   = new_ff;
                  next_wdata = nb_sel;
                  prev_we    = 1'b1;
                  prev_wid   = new_ff;
                  prev_wdata = anchor_ff;
                  state_in   = S_WR2;
               end
               BP: begin
                  next_we    = 1'b1;
                  next_wid   = new_ff;
                  next_wdata = anchor_ff;
                  prev_we    = 1'b1;
                  prev_wid   = new_ff;
                  prev_wdata = nb_sel;
                  state_in   = S_WR2;
               end
               default: state_in = S_READ2;
            endcase
         end
         S_READ2: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            if (func_ff == CN) begin
               prev_wid   = nb_sel;
               prev_wdata = anchor_ff;
               next_wid   = anchor_ff;
               next_wdata = nb_sel;
            end else begin
               next_wid   = nb_sel;
               next_wdata = anchor_ff;
               prev_wid   = anchor_ff;
               prev_wdata = nb_sel;
            end
            state_in = S_DONE;
         end
         S_WR2: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            if (func_ff == BN) begin
               next_wid   = anchor_ff;
               next_wdata = new_ff;
               prev_wid   = n_ff;
               prev_wdata = new_ff;
            end else begin
               next_wid   = n_ff;
               next_wdata = new_ff;
               prev_wid   = anchor_ff;
               prev_wdata = new_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = n_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      anchor_ff   <= anchor_in;
      new_ff      <= new_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         recent_ff    <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         recent_ff    <= recent_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[slot(next_wid)] <= next_wdata;
      end
      next_rd_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[slot(prev_wid)] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[rd_addr];
   end

endmodule

>>> src/clle_checker.sv
module clle_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [clle_pkg::REQ_W-1:0]  req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [clle_pkg::RSP_W-1:0]  rsp_tdata
);
   import clle_pkg::*;

   logic     req_fire;
   func_type req_func;
   logic     is_op;

   assign req_fire = req_tvalid && req_tready;
   assign req_func = req_tdata[FUNC_W-1:0];
   assign is_op    = (req_func == BN) || (req_func == BP) || (req_func == CN) ||
                     (req_func == CP);

   // A stalled result holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A new result only appears at the end of work, when no request was being taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without work in progress");

   // A load transaction occupies the engine for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_func == FUNC_LOAD) |=> !req_tready)
      else $error("engine ready straight after a load");

   // An insert or a delete needs its read before any further request.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && is_op |=> !req_tready ##1 !req_tready)
      else $error("engine ready too early after an operation");

endmodule

bind circular_linked_list_engine clle_checker u_clle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/circular_linked_list_engine_tb.sv
`timescale 1ns / 1ps

module circular_linked_list_engine_tb;
   import clle_pkg::*;

   localparam func_type FUNC_TOP      = 3'd7;
   localparam id_type   ID_TOP        = '1;
   localparam int       DRAIN_LIMIT   = 20000;
   localparam int       SETTLE_CYCLES = 20;
   localparam int       PRINT_LIMIT   = 40;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   id_type next_tbl [NODE_COUNT];
   id_type prev_tbl [NODE_COUNT];
   bit     next_wr  [NODE_COUNT];
   bit     prev_wr  [NODE_COUNT];
   id_type first_id   = '0;
   id_type recent_id  = '0;
   bit     load_open  = 1'b0;
   id_type ring_entry = '0;
   bit     have_ring  = 1'b0;

   id_type neighbour_q [$];
   id_type want_id;
   int     error_count   = 0;
   int     send_idle_pct = 0;
   int     stall_pct     = 0;

   circular_linked_list_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic void put_next(input id_type idx, input id_type val);
      next_tbl[idx] = val;
      next_wr[idx]  = 1'b1;
   endfunction

   function automatic void put_prev(input id_type idx, input id_type val);
      prev_tbl[idx] = val;
      prev_wr[idx]  = 1'b1;
   endfunction

   // Updates the ring copy for one accepted transaction and queues the neighbour it reports.
   task automatic apply_item(input func_type f, input id_type a, input id_type nw,
                             input logic last);
      id_type n;
      id_type nn;
      case (f)
         FUNC_LOAD: begin
            if (!load_open) begin
               first_id  = nw;
               recent_id = nw;
               load_open = 1'b1;
            end
            put_prev(nw, recent_id);
            put_next(recent_id, nw);
            put_next(nw, first_id);
            put_prev(first_id, nw);
            recent_id = nw;
            if (last) begin
               load_open = 1'b0;
            end
         end
         BN: begin
            n = next_tbl[a];
            put_next(nw, n);
            put_prev(nw, a);
            put_prev(n, nw);
            put_next(a, nw);
            neighbour_q.push_back(n);
         end
         BP: begin
            n = prev_tbl[a];
            put_next(nw, a);
            put_prev(nw, n);
            put_next(n, nw);
            put_prev(a, nw);
            neighbour_q.push_back(n);
         end
         CN: begin
            n  = next_tbl[a];
            nn = next_tbl[n];
            put_prev(nn, a);
            put_next(a, nn);
            neighbour_q.push_back(n);
         end
         CP: begin
            n  = prev_tbl[a];
            nn = prev_tbl[n];
            put_next(nn, a);
            put_prev(a, nn);
            neighbour_q.push_back(n);
         end
         default: begin
         end
      endcase
   endtask

   function automatic bit reads_ok(input func_type f, input id_type a);
      case (f)
         BN:      return next_wr[a];
         BP:      return prev_wr[a];
         CN:      return next_wr[a] && next_wr[next_tbl[a]];
         CP:      return prev_wr[a] && prev_wr[prev_tbl[a]];
         default: return 1'b1;
      endcase
   endfunction

   function automatic int ring_size();
      id_type p;
      int     cnt;
      p   = ring_entry;
      cnt = 1;
      while (next_wr[p] && next_tbl[p] != ring_entry && cnt < NODE_COUNT) begin
         p = next_tbl[p];
         cnt++;
      end
      return cnt;
   endfunction

   function automatic bit on_ring(input id_type id);
      id_type p;
      int     cnt;
      p   = ring_entry;
      cnt = 0;
      while (cnt < NODE_COUNT) begin
         if (p == id) return 1'b1;
         if (!next_wr[p] || next_tbl[p] == ring_entry) return 1'b0;
         p = next_tbl[p];
         cnt++;
      end
      return 1'b0;
   endfunction

   function automatic id_type pick_member(input int size);
      id_type p;
      int     steps;
      p     = ring_entry;
      steps = $urandom_range(0, size - 1);
      while (steps > 0 && next_wr[p]) begin
         p = next_tbl[p];
         steps--;
      end
      return p;
   endfunction

   function automatic id_type fresh_id();
      id_type c;
      int     tries;
      c     = id_type'($urandom);
      tries = 0;
      while (on_ring(c) && tries < 32) begin
         c = id_type'($urandom);
         tries++;
      end
      return c;
   endfunction

   task automatic send_item(input func_type f, input id_type a, input id_type nw,
                            input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - REQ_BITS){1'b0}}, nw, a, f};
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      apply_item(f, a, nw, last);
   endtask

   task automatic wait_for_results();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (neighbour_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (neighbour_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", neighbour_q.size()));
         neighbour_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (neighbour_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, neighbour_id %0d",
                                      rsp_tdata[ID_W-1:0]));
         end else begin
            want_id = neighbour_q.pop_front();
            if (rsp_tdata[ID_W-1:0] !== want_id) begin
               report_mismatch($sformatf("neighbour_id %0d, expected %0d",
                                         rsp_tdata[ID_W-1:0], want_id));
            end
         end
      end
   end

   task automatic test_single_node_ring();
      send_item(FUNC_LOAD, ID_TOP, ID_TOP, 1'b1);
      send_item(CN, ID_TOP, 10'h000, 1'b0);
      send_item(BN, ID_TOP, 10'h000, 1'b1);
      send_item(CP, 10'h000, ID_TOP, 1'b0);
      send_item(BP, 10'h000, 10'h155, 1'b0);
      send_item(CP, 10'h155, 10'h000, 1'b1);
      ring_entry = 10'h155;
      have_ring  = 1'b1;
   endtask

   task automatic test_unknown_funcs();
      int f;
      for (f = CP + 1; f <= FUNC_TOP; f++) begin
         send_item(func_type'(f), id_type'($urandom), id_type'($urandom), 1'($urandom));
      end
   endtask

   // Operations arrive in an open load run; an op's tlast does not close it, a load's does.
   task automatic test_load_with_operations();
      send_item(FUNC_LOAD, id_type'($urandom), 10'h000, 1'b0);
      send_item(FUNC_LOAD, id_type'($urandom), 10'h2AA, 1'b0);
      send_item(BN, 10'h000, 10'h155, 1'b1);
      send_item(FUNC_LOAD, id_type'($urandom), ID_TOP, 1'b1);
      send_item(FUNC_LOAD, id_type'($urandom), 10'h0F0, 1'b1);
      ring_entry = 10'h0F0;
   endtask

   task automatic test_extreme_ids();
      send_item(FUNC_LOAD, ID_TOP, 10'h000, 1'b0);
      send_item(FUNC_LOAD, 10'h000, ID_TOP, 1'b0);
      send_item(FUNC_LOAD, 10'h2AA, 10'h155, 1'b0);
      send_item(FUNC_LOAD, 10'h155, 10'h2AA, 1'b1);
      send_item(CN, ID_TOP, ID_TOP, 1'b0);
      send_item(CP, 10'h000, 10'h000, 1'b1);
      send_item(BN, 10'h000, 10'h0F0, 1'b0);
      send_item(BP, ID_TOP, 10'h30F, 1'b0);
      // The new id is already on the ring here.
      send_item(BN, 10'h000, ID_TOP, 1'b0);
      ring_entry = 10'h000;
   endtask

   task automatic test_random_traffic(input int count);
      int       done;
      int       size;
      int       sel;
      bit       grow;
      func_type f;
      id_type   a;
      id_type   nw;
      done = 0;
      while (done < count) begin
         sel  = $urandom_range(0, 99);
         size = ring_size();
         if (!have_ring || sel < 14) begin
            nw = load_open ? fresh_id() : id_type'($urandom);
            send_item(FUNC_LOAD, id_type'($urandom), nw, $urandom_range(0, 3) == 0);
            ring_entry = nw;
            have_ring  = 1'b1;
            done++;
         end else if (sel < 18) begin
            send_item(func_type'($urandom_range(CP + 1, FUNC_TOP)), id_type'($urandom),
                      id_type'($urandom), 1'($urandom));
         end else if (sel < 24) begin
            f = func_type'($urandom_range(BN, CP));
            a = id_type'($urandom);
            if (reads_ok(f, a)) begin
               send_item(f, a, id_type'($urandom), 1'($urandom));
               done++;
            end
         end else begin
            a = pick_member(size);
            if (sel < 28) begin
               f  = $urandom_range(0, 1) ? BN : BP;
               nw = pick_member(size);
            end else begin
               if (size < 4) begin
                  grow = ($urandom_range(0, 9) < 8);
               end else if (size > 40) begin
                  grow = ($urandom_range(0, 9) < 2);
               end else begin
                  grow = 1'($urandom_range(0, 1));
               end
               if (grow) begin
                  f  = $urandom_range(0, 1) ? BN : BP;
                  nw = fresh_id();
               end else begin
                  f  = $urandom_range(0, 1) ? CN : CP;
                  nw = id_type'($urandom);
               end
            end
            if (reads_ok(f, a)) begin
               send_item(f, a, nw, 1'($urandom));
               ring_entry = a;
               done++;
            end
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      stall_pct     = 0;
      test_single_node_ring();
      test_unknown_funcs();
      test_load_with_operations();
      test_extreme_ids();
      wait_for_results();

      test_random_traffic(340);

      send_idle_pct = 82;
      stall_pct     = 0;
      test_random_traffic(330);

      send_idle_pct = 0;
      stall_pct     = 82;
      test_random_traffic(330);

      send_idle_pct = 32;
      stall_pct     = 32;
      test_random_traffic(330);

      wait_for_results();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> circular_linked_list_engine.f
src/clle_pkg.sv
src/circular_linked_list_engine.sv
src/clle_checker.sv
tb/sv/circular_linked_list_engine_tb.sv
